FILE: hw/rtl/sm3_pkg.sv
// Package for the SM3 hash engine: constants, shared types and round helper functions.
// It has no dependencies. The scheduler, the round unit and the top-level engine import it.
`default_nettype none

package sm3_pkg;

    localparam int WORD_W   = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS   = 64;
    localparam int DIGEST_WORDS = 8;

    typedef logic [WORD_W-1:0] sm3_word_t;
    typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] sm3_state_t;

    localparam sm3_state_t SM3_IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    localparam sm3_word_t T_LOW  = 32'h79CC4519;
    localparam sm3_word_t T_HIGH = 32'h7A879D8A;
    localparam sm3_word_t PAD_WORD = 32'h8000_0000;
    localparam logic [3:0] LEN_WORD_POS = 4'd14;

    typedef struct packed {
        logic push;
        logic expand;
    } sm3_sched_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } sm3_round_ctrl_t;

    function automatic sm3_word_t rotl32(input sm3_word_t x, input logic [4:0] n);
        sm3_word_t dbl_lo;
        dbl_lo = (x << n) | ((n == 5'd0) ? '0 : (x >> (6'd32 - {1'b0, n})));
        return dbl_lo;
    endfunction

    function automatic sm3_word_t perm0(input sm3_word_t x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic sm3_word_t perm1(input sm3_word_t x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    function automatic sm3_word_t round_const(input logic [5:0] j);
        return rotl32((j < 6'd16) ? T_LOW : T_HIGH, j[4:0]);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sm3_if.sv
// Handshake interfaces for the message word channel and the digest word channel.
// They have no dependencies.
`default_nettype none

interface sm3_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;

    modport source (output valid, output message_word, output valid_bytes,
                    output end_of_message, input ready);
    modport sink (input valid, input message_word, input valid_bytes,
                  input end_of_message, output ready);
endinterface

interface sm3_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sm3_sched.sv
// Block buffer and message expansion of the SM3 engine as a 16-word sliding window.
// It depends on sm3_pkg.
`default_nettype none

module sm3_sched
    import sm3_pkg::*;
(
    input  wire logic            clk,
    input  wire sm3_sched_ctrl_t ctrl,
    input  wire sm3_word_t       word,
    output sm3_word_t            w_cur,
    output sm3_word_t            w_ahead
);

    sm3_word_t win_reg [BLOCK_WORDS];
    sm3_word_t expanded;

    assign expanded = perm1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 5'd15))
                      ^ rotl32(win_reg[3], 5'd7) ^ win_reg[10];
    assign w_cur   = win_reg[0];
    assign w_ahead = win_reg[4];

    always_ff @(posedge clk)
    begin
        if (ctrl.push || ctrl.expand)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLOCK_WORDS-1] <= ctrl.push ? word : expanded;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sm3_round.sv
// Shared SM3 round unit: eight working registers updated by one round per cycle while step is set.
// It depends on sm3_pkg.
`default_nettype none

module sm3_round
    import sm3_pkg::*;
(
    input  wire logic            clk,
    input  wire sm3_round_ctrl_t ctrl,
    input  wire logic [5:0]      round,
    input  wire sm3_word_t       w_cur,
    input  wire sm3_word_t       w_ahead,
    input  wire sm3_state_t      cv,
    output sm3_state_t           v
);

    sm3_state_t v_reg;
    sm3_state_t v_next;
    sm3_word_t  a12;
    sm3_word_t  ss1;
    sm3_word_t  ss2;
    sm3_word_t  ff;
    sm3_word_t  gg;
    sm3_word_t  tt1;
    sm3_word_t  tt2;

    always_comb
    begin
        a12 = rotl32(v_reg[0], 5'd12);
        ss1 = rotl32(a12 + v_reg[4] + round_const(round), 5'd7);
        ss2 = ss1 ^ a12;
        if (round < 6'd16)
        begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end
        else
        begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (w_cur ^ w_ahead);
        tt2 = gg + v_reg[7] + ss1 + w_cur;
        v_next[0] = tt1;
        v_next[1] = v_reg[0];
        v_next[2] = rotl32(v_reg[1], 5'd9);
        v_next[3] = v_reg[2];
        v_next[4] = perm0(tt2);
        v_next[5] = v_reg[4];
        v_next[6] = rotl32(v_reg[5], 5'd19);
        v_next[7] = v_reg[6];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_reg <= cv;
        end
        else if (ctrl.step)
        begin
            v_reg <= v_next;
        end
    end

    assign v = v_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sm3_hash_engine.sv
// SM3 hash engine: one message word per transaction, eight digest words per message.
// The word that fills a block starts a compression: the rounds, then a fold into the chaining value,
// all on the single shared round unit.
// The final word adds the padding words and one or two compressions, then eight digest
// transactions; no word is taken meanwhile.
// Reset loads the initial value and clears the word and bit counts; no clearing pass.
`default_nettype none

module sm3_hash_engine
    import sm3_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    sm3_msg_if.sink     message,
    sm3_digest_if.source digest
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PK_MARK,
        PK_ZERO,
        PK_LENLO,
        PK_DONE
    } pad_kind_t;

    state_t          state_reg;
    pad_kind_t       kind_reg;
    logic            pad_active_reg;
    logic [3:0]      count_reg;
    logic [63:0]     bits_reg;
    logic [5:0]      round_reg;
    logic [2:0]      idx_reg;
    sm3_state_t      cv_reg;

    logic            accept;
    logic [2:0]      nbytes;
    sm3_word_t       final_word;
    sm3_word_t       push_word;
    logic            push_en;
    logic            full;
    sm3_sched_ctrl_t sched_ctrl;
    sm3_round_ctrl_t round_ctrl;
    sm3_word_t       w_cur;
    sm3_word_t       w_ahead;
    sm3_state_t      v;

    assign message.ready = (state_reg == ST_IDLE);
    assign accept = message.valid && message.ready;
    assign nbytes = (message.valid_bytes > 3'd4) ? 3'd4 : message.valid_bytes;

    always_comb
    begin
        case (nbytes)
            3'd0:    final_word = PAD_WORD;
            3'd1:    final_word = (message.message_word & 32'hFF00_0000) | 32'h0080_0000;
            3'd2:    final_word = (message.message_word & 32'hFFFF_0000) | 32'h0000_8000;
            3'd3:    final_word = (message.message_word & 32'hFFFF_FF00) | 32'h0000_0080;
            default: final_word = message.message_word;
        endcase
    end

    always_comb
    begin
        push_word = '0;
        push_en   = 1'b0;
        if (state_reg == ST_IDLE)
        begin
            push_en   = accept;
            push_word = message.end_of_message ? final_word : message.message_word;
        end
        else if (state_reg == ST_PAD)
        begin
            case (kind_reg)
                PK_MARK:
                begin
                    push_en   = 1'b1;
                    push_word = PAD_WORD;
                end
                PK_ZERO:
                begin
                    push_en   = 1'b1;
                    push_word = (count_reg == LEN_WORD_POS) ? bits_reg[63:32] : '0;
                end
                PK_LENLO:
                begin
                    push_en   = 1'b1;
                    push_word = bits_reg[31:0];
                end
                default:
                begin
                    push_en   = 1'b0;
                    push_word = '0;
                end
            endcase
        end
    end

    assign full = push_en && (count_reg == 4'd15);

    assign sched_ctrl.push   = push_en;
    assign sched_ctrl.expand = (state_reg == ST_COMP);
    assign round_ctrl.load   = full;
    assign round_ctrl.step   = (state_reg == ST_COMP);

    sm3_sched u_sched (
        .clk     (clk),
        .ctrl    (sched_ctrl),
        .word    (push_word),
        .w_cur   (w_cur),
        .w_ahead (w_ahead)
    );

    sm3_round u_round (
        .clk     (clk),
        .ctrl    (round_ctrl),
        .round   (round_reg),
        .w_cur   (w_cur),
        .w_ahead (w_ahead),
        .cv      (cv_reg),
        .v       (v)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= PK_DONE;
            pad_active_reg <= 1'b0;
            count_reg      <= '0;
            bits_reg       <= '0;
            round_reg      <= '0;
            idx_reg        <= '0;
            cv_reg         <= SM3_IV;
        end
        else
        begin
            if (push_en)
            begin
                count_reg <= count_reg + 4'd1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        round_reg <= '0;
                        if (message.end_of_message)
                        begin
                            bits_reg       <= bits_reg + 64'({nbytes, 3'b000});
                            pad_active_reg <= 1'b1;
                            kind_reg       <= (nbytes == 3'd4) ? PK_MARK : PK_ZERO;
                            state_reg      <= full ? ST_COMP : ST_PAD;
                        end
                        else
                        begin
                            bits_reg  <= bits_reg + 64'd32;
                            state_reg <= full ? ST_COMP : ST_IDLE;
                        end
                    end
                end
                ST_PAD:
                begin
                    round_reg <= '0;
                    case (kind_reg)
                        PK_MARK:  kind_reg <= PK_ZERO;
                        PK_ZERO:  kind_reg <= (count_reg == LEN_WORD_POS) ? PK_LENLO : PK_ZERO;
                        PK_LENLO: kind_reg <= PK_DONE;
                        default:  kind_reg <= PK_DONE;
                    endcase
                    state_reg <= full ? ST_COMP : ST_PAD;
                end
                ST_COMP:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(ROUNDS - 1))
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    cv_reg  <= cv_reg ^ v;
                    idx_reg <= '0;
                    if (!pad_active_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (kind_reg == PK_DONE)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_PAD;
                    end
                end
                ST_OUT:
                begin
                    if (digest.ready)
                    begin
                        if (idx_reg == 3'(DIGEST_WORDS - 1))
                        begin
                            cv_reg         <= SM3_IV;
                            bits_reg       <= '0;
                            count_reg      <= '0;
                            pad_active_reg <= 1'b0;
                            kind_reg       <= PK_DONE;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = cv_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == 3'(DIGEST_WORDS - 1));

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the SM3 hash engine. It drives message words, tracks the
// expected digests with its own SM3 predictor, and checks every digest transaction.
// It depends on sm3_pkg (hw/rtl/sm3_pkg.sv), the channel interfaces and sm3_hash_engine.

module testbench;
    import sm3_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    class sm3_digest_book;
        sm3_state_t   chain;
        sm3_word_t    block_words[16];
        int unsigned  fill;
        bit [63:0]    bit_count;
        digest_beat_t awaited[$];
        int unsigned  mismatches;
        int unsigned  checked;

        function new();
            chain = SM3_IV;
            fill = 0;
            bit_count = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function sm3_word_t rol(sm3_word_t v, int unsigned n);
            int unsigned s;
            s = n % 32;
            if (s == 0)
                return v;
            return (v << s) | (v >> (32 - s));
        endfunction

        function sm3_word_t mix_p0(sm3_word_t x);
            return x ^ rol(x, 9) ^ rol(x, 17);
        endfunction

        function sm3_word_t mix_p1(sm3_word_t x);
            return x ^ rol(x, 15) ^ rol(x, 23);
        endfunction

        function void compress_block();
            sm3_word_t w[68];
            sm3_word_t a, b, c, d, e, f, g, h;
            sm3_word_t a12, ss1, ss2, ff, gg, tt1, tt2, tj;
            int j;
            for (j = 0; j < 16; j++)
                w[j] = block_words[j];
            for (j = 16; j < 68; j++)
                w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (j = 0; j < 64; j++)
            begin
                tj = (j < 16) ? T_LOW : T_HIGH;
                a12 = rol(a, 12);
                ss1 = rol(a12 + e + rol(tj, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16)
                begin
                    ff = a ^ b ^ c;
                    gg = e ^ f ^ g;
                end
                else
                begin
                    ff = (a & b) | (a & c) | (b & c);
                    gg = (e & f) | (~e & g);
                end
                tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
                tt2 = gg + h + ss1 + w[j];
                d = c;
                c = rol(b, 9);
                b = a;
                a = tt1;
                h = g;
                g = rol(f, 19);
                f = e;
                e = mix_p0(tt2);
            end
            chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
            chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
        endfunction

        function void append_word(sm3_word_t w);
            block_words[fill] = w;
            fill = (fill + 1) % 16;
            if (fill == 0)
                compress_block();
        endfunction

        // Called for every accepted message transaction; a final word queues eight digest words.
        function void take_word(sm3_word_t word, bit [2:0] nbytes, bit eom);
            int unsigned n;
            sm3_word_t keep;
            digest_beat_t beat;
            int k;
            if (!eom)
            begin
                bit_count += 64'd32;
                append_word(word);
            end
            else
            begin
                n = (nbytes > 4) ? 4 : nbytes;
                bit_count += 64'(n * 8);
                if (n == 4)
                begin
                    append_word(word);
                    append_word(PAD_WORD);
                end
                else
                begin
                    keep = (n == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * n));
                    append_word((word & keep) | (PAD_WORD >> (8 * n)));
                end
                while (fill != 14)
                    append_word('0);
                append_word(bit_count[63:32]);
                append_word(bit_count[31:0]);
                for (k = 0; k < 8; k++)
                begin
                    beat.digest_word = chain[k];
                    beat.word_index = k[2:0];
                    beat.last_word = (k == 7);
                    awaited.push_back(beat);
                end
                chain = SM3_IV;
                fill = 0;
                bit_count = '0;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_digest_word(logic [31:0] word, logic [2:0] idx, logic last);
            digest_beat_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected digest word %h index %0d", word, idx));
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                if (word !== want.digest_word)
                    report($sformatf("digest word %0d is %h, want %h",
                                     want.word_index, word, want.digest_word));
                if (idx !== want.word_index)
                    report($sformatf("word index is %0d, want %0d", idx, want.word_index));
                if (last !== want.last_word)
                    report($sformatf("last flag on word %0d is %b, want %b",
                                     want.word_index, last, want.last_word));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    sm3_msg_if    msg_ch ();
    sm3_digest_if dig_ch ();

    sm3_hash_engine uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .message(msg_ch),
        .digest (dig_ch)
    );

    sm3_digest_book book;
    int unsigned    src_idle_pct;
    int unsigned    snk_idle_pct;
    int unsigned    words_sent;
    int unsigned    messages_sent;
    int unsigned    beats_seen;
    int unsigned    hold_left;
    bit             hold_done;
    int unsigned    quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_word(input sm3_word_t word, input bit [2:0] nbytes, input bit eom);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.message_word <= word;
        msg_ch.valid_bytes <= nbytes;
        msg_ch.end_of_message <= eom;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        book.take_word(word, nbytes, eom);
        words_sent++;
        if (eom)
            messages_sent++;
    endtask

    function automatic sm3_word_t pick_word();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic send_random_message();
        int unsigned body;
        int unsigned i;
        body = ($urandom_range(3) == 0) ? $urandom_range(40, 13) : $urandom_range(15, 0);
        for (i = 0; i < body; i++)
            send_word(pick_word(), 3'($urandom_range(7)), 1'b0);
        send_word(pick_word(), 3'($urandom_range(7)), 1'b1);
    endtask

    // The receiver holds off once for a long stretch while digest words wait, so the
    // engine backs up and stops taking message transactions.
    initial
    begin
        dig_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (dig_ch.valid && dig_ch.ready)
            begin
                book.check_digest_word(dig_ch.digest_word, dig_ch.word_index,
                                       dig_ch.last_word);
                beats_seen++;
            end
            if (hold_left == 0 && !hold_done && dig_ch.valid && beats_seen >= 16)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_ch.ready <= 1'b0;
            end
            else
                dig_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned i;
        int phase;
        book = new();
        words_sent = 0;
        messages_sent = 0;
        beats_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        quiet_cycles = 0;
        src_idle_pct = 30;
        snk_idle_pct = 49;
        rst_n <= 1'b0;
        msg_ch.valid <= 1'b0;
        msg_ch.message_word <= '0;
        msg_ch.valid_bytes <= '0;
        msg_ch.end_of_message <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
        send_word(32'h1234_5678, 3'd5, 1'b1);
        send_word(32'h89AB_CDEF, 3'd6, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_word(32'hA5A5_A5A5, 3'd2, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        // Fourteen full words: the padding spills into a second block.
        for (i = 0; i < 13; i++)
            send_word({4{8'(i * 17 + 1)}}, 3'(i), 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);

        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 49 : 0;
            snk_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 30 : 0;
            while (words_sent < 24 + (phase + 1) * 105)
                send_random_message();
        end
        msg_ch.valid <= 1'b0;

        while (book.awaited.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("summary: %0d messages of %0d words hashed, %0d digest words checked",
                 messages_sent, words_sent, book.checked);
        $display("summary: %0d mismatches, long receiver hold %s", book.mismatches,
                 hold_done ? "applied" : "not reached");
        if (book.mismatches == 0 && book.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
